### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the echo block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// widths, register map, reset values and shared types of the echo block
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int MAX_DELAY_DEF = 262144;

	localparam int SAMPLE_W  = 16;
	localparam int GAIN_W    = 9;
	localparam int LEN_CFG_W = 19;
	localparam int MODE_W    = 2;
	localparam int COEF_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 19;
	localparam int FV_W      = 32;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FB     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A0     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd7;

	// filter modes, anything above low-pass acts as high-pass
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOW  = 2'd1;

	// register reset values
	localparam logic [GAIN_W-1:0]    DRY_RST    = 9'd256;
	localparam logic [GAIN_W-1:0]    WET_RST    = 9'd40;
	localparam logic [GAIN_W-1:0]    FB_RST     = 9'd128;
	localparam logic [LEN_CFG_W-1:0] LEN_RST    = 19'd44100;
	localparam logic [LEN_CFG_W-1:0] OFFSET_RST = 19'd22050;

	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

endpackage

### hdl/stereo_feedback_echo.sv
// ----------------------------------------------------------------------------
// stereo_feedback_echo
// stereo feedback echo with optional one-pole filter in the loop
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one stereo frame per beat
//   (in_left, in_right); output channel: out_valid / out_stall carry one
//   stereo result per beat (out_left, out_right), one result per frame
//   config: cfg_wr_en writes cfg_data into register cfg_index; the user
//   writes only while idle, the block itself does not enforce it
//   frame: setup, address, per channel load, filter steps if the filter is
//   on, mix and write-back, then a right store update unless the right offset
//   lands on the pointer; a frame is taken only once the last is done, as the
//   single shared multiplier works in turn and each delay store has one port
//   reset: config registers take their defaults, pointer and filter state
//   clear, then both delay stores are swept to zero over all MAX_DELAY
//   entries, with in_stall high for the whole sweep
//   output stall: the finished result sits in the output register; the next
//   frame is taken and processed meanwhile and waits at its end until the
//   output register frees up
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stereo_feedback_echo #(
	parameter int MAX_DELAY = sfe_pkg::MAX_DELAY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfe_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [sfe_pkg::SAMPLE_W-1:0] in_left,
	input  logic signed [sfe_pkg::SAMPLE_W-1:0] in_right,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sfe_pkg::SAMPLE_W-1:0] out_left,
	output logic signed [sfe_pkg::SAMPLE_W-1:0] out_right
);

	localparam int PTR_W = $clog2(MAX_DELAY);
	localparam int LEN_W = PTR_W + 1;
	localparam int SUM_W = LEN_W + 1;
	localparam int CMP_W = (LEN_W > sfe_pkg::LEN_CFG_W) ? LEN_W : sfe_pkg::LEN_CFG_W;
	localparam int SW    = sfe_pkg::SAMPLE_W;
	localparam int AW    = sfe_pkg::MUL_A_W;
	localparam int BW    = sfe_pkg::MUL_B_W;
	localparam int PW    = sfe_pkg::PROD_W;
	localparam int FW    = sfe_pkg::FV_W;

	// sequencer states
	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_SETUP = 5'd2;
	localparam logic [4:0] S_ADDR  = 5'd3;
	localparam logic [4:0] S_LOAD  = 5'd4;
	localparam logic [4:0] S_F1    = 5'd5;
	localparam logic [4:0] S_F2    = 5'd6;
	localparam logic [4:0] S_F3    = 5'd7;
	localparam logic [4:0] S_F4    = 5'd8;
	localparam logic [4:0] S_F5    = 5'd9;
	localparam logic [4:0] S_W1    = 5'd10;
	localparam logic [4:0] S_W2    = 5'd11;
	localparam logic [4:0] S_W3    = 5'd12;
	localparam logic [4:0] S_W4    = 5'd13;
	localparam logic [4:0] S_Q1    = 5'd14;
	localparam logic [4:0] S_Q2    = 5'd15;
	localparam logic [4:0] S_DONE  = 5'd16;

	// product / 256 truncating toward zero, wrapped to 16 bits
	function automatic logic [SW-1:0] div256_wrap(input logic signed [PW-1:0] p);
		logic neg_frac;
		neg_frac = p[PW-1] && (p[7:0] != 8'd0);
		return p[23:8] + {{(SW-1){1'b0}}, neg_frac};
	endfunction

	// config registers
	logic [sfe_pkg::GAIN_W-1:0]    dry_gain_q, wet_gain_q, feedback_gain_q;
	logic [sfe_pkg::LEN_CFG_W-1:0] delay_length_q, right_offset_q;
	logic [sfe_pkg::MODE_W-1:0]    filter_mode_q;
	logic [sfe_pkg::COEF_W-1:0]    coef_a0_q, coef_b1_q;

	// control
	logic [4:0]       state_q;
	logic [PTR_W-1:0] clr_q;
	logic [PTR_W-1:0] ptr_q;
	logic [LEN_W-1:0] len_q, off_q;
	logic [PTR_W-1:0] p_q, q_q;
	logic             same_q;
	logic             ch_q;
	logic             out_valid_q;

	// datapath
	logic signed [SW-1:0] in_l_q, in_r_q;
	logic signed [AW-1:0] v_q;
	logic [FW-1:0]        acc_q;
	logic [SW-1:0]        wet_q, fbv_q;
	logic signed [FW-1:0] fv_q [2];
	logic signed [SW-1:0] rem_q [2];
	logic [SW-1:0]        res_q [2];
	logic [SW-1:0]        out_left_q, out_right_q;

	// shared multiplier
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod;

	// delay stores
	sfe_pkg::ram_ctl_t ctl_l, ctl_r;
	logic [PTR_W-1:0]  addr_l, addr_r;
	logic [SW-1:0]     wdata_l, wdata_r, rdata_l, rdata_r;

	// combinational helpers
	logic [CMP_W-1:0]     len_ext, off_ext, len_eff, off_eff;
	logic [SUM_W-1:0]     q_sum, q_wrap;
	logic [LEN_W-1:0]     ptr_nxt;
	logic signed [SW-1:0] in_ch;
	logic [SW-1:0]        rd_ch;
	logic [SW-1:0]        wb_data;
	logic                 clearing;
	logic                 neg_frac;
	logic signed [FW-1:0] fv_new;
	logic signed [SW-1:0] rem_new;
	logic                 out_free;

	assign clearing = (state_q == S_CLEAR);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign in_ch = ch_q ? in_r_q : in_l_q;
	assign rd_ch = ch_q ? rdata_r : rdata_l;

	// effective length, offset clamp
	always_comb begin
		len_ext = CMP_W'(delay_length_q);
		off_ext = CMP_W'(right_offset_q);
		if (len_ext == '0) begin
			len_eff = CMP_W'(1);
		end else if (len_ext > CMP_W'(MAX_DELAY)) begin
			len_eff = CMP_W'(MAX_DELAY);
		end else begin
			len_eff = len_ext;
		end
		off_eff = (off_ext > len_eff) ? len_eff : off_ext;
	end

	// right write position, wraps once at the length
	always_comb begin
		q_sum  = SUM_W'(p_q) + SUM_W'(off_q);
		q_wrap = (q_sum >= SUM_W'(len_q)) ? (q_sum - SUM_W'(len_q)) : q_sum;
	end

	assign ptr_nxt = LEN_W'(p_q) + LEN_W'(1);

	// filter split: acc / 32768 and acc rem 32768, both toward zero
	always_comb begin
		neg_frac = acc_q[FW-1] && (acc_q[14:0] != 15'd0);
		fv_new   = {{15{acc_q[FW-1]}}, acc_q[FW-1:15]} + {{(FW-1){1'b0}}, neg_frac};
		rem_new  = {neg_frac, acc_q[14:0]};
	end

	// write-back at the pointer; input folds in unless right goes elsewhere
	assign wb_data = (!ch_q || same_q) ? (fbv_q + in_ch) : fbv_q;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_F1: begin
				mul_a = v_q;
				mul_b = signed'(BW'(coef_a0_q));
			end
			S_F2: begin
				mul_a = AW'(fv_q[ch_q]);
				mul_b = signed'(BW'(coef_b1_q));
			end
			S_W1: begin
				mul_a = v_q;
				mul_b = signed'(BW'(wet_gain_q));
			end
			S_W2: begin
				mul_a = v_q;
				mul_b = signed'(BW'(feedback_gain_q));
			end
			S_W3: begin
				mul_a = AW'(in_ch);
				mul_b = signed'(BW'(dry_gain_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// store port control
	always_comb begin
		ctl_l.we = clearing || (state_q == S_W4 && !ch_q);
		ctl_l.re = (state_q == S_ADDR);
		ctl_r.we = clearing || (state_q == S_W4 && ch_q) || (state_q == S_Q2);
		ctl_r.re = (state_q == S_ADDR) || (state_q == S_Q1);
		addr_l   = clearing ? clr_q : p_q;
		if (clearing) begin
			addr_r = clr_q;
		end else if (state_q == S_Q1 || state_q == S_Q2) begin
			addr_r = q_q;
		end else begin
			addr_r = p_q;
		end
		wdata_l = clearing ? '0 : wb_data;
		if (clearing) begin
			wdata_r = '0;
		end else if (state_q == S_Q2) begin
			wdata_r = rdata_r + in_r_q;
		end else begin
			wdata_r = wb_data;
		end
	end

	sfe_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	sfe_ram #(
		.DEPTH (MAX_DELAY)
	) u_ram_l (
		.clk   (clk),
		.ctl   (ctl_l),
		.addr  (addr_l),
		.wdata (wdata_l),
		.rdata (rdata_l)
	);

	sfe_ram #(
		.DEPTH (MAX_DELAY)
	) u_ram_r (
		.clk   (clk),
		.ctl   (ctl_r),
		.addr  (addr_r),
		.wdata (wdata_r),
		.rdata (rdata_r)
	);

	// config register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_gain_q      <= sfe_pkg::DRY_RST;
			wet_gain_q      <= sfe_pkg::WET_RST;
			feedback_gain_q <= sfe_pkg::FB_RST;
			delay_length_q  <= sfe_pkg::LEN_RST;
			right_offset_q  <= sfe_pkg::OFFSET_RST;
			filter_mode_q   <= sfe_pkg::MODE_NONE;
			coef_a0_q       <= '0;
			coef_b1_q       <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sfe_pkg::REG_DRY:    dry_gain_q      <= cfg_data[sfe_pkg::GAIN_W-1:0];
				sfe_pkg::REG_WET:    wet_gain_q      <= cfg_data[sfe_pkg::GAIN_W-1:0];
				sfe_pkg::REG_FB:     feedback_gain_q <= cfg_data[sfe_pkg::GAIN_W-1:0];
				sfe_pkg::REG_LEN:    delay_length_q  <= cfg_data[sfe_pkg::LEN_CFG_W-1:0];
				sfe_pkg::REG_OFFSET: right_offset_q  <= cfg_data[sfe_pkg::LEN_CFG_W-1:0];
				sfe_pkg::REG_MODE:   filter_mode_q   <= cfg_data[sfe_pkg::MODE_W-1:0];
				sfe_pkg::REG_A0:     coef_a0_q       <= cfg_data[sfe_pkg::COEF_W-1:0];
				sfe_pkg::REG_B1:     coef_b1_q       <= cfg_data[sfe_pkg::COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ptr_q       <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			fv_q[0]     <= '0;
			fv_q[1]     <= '0;
			rem_q[0]    <= '0;
			rem_q[1]    <= '0;
		end else begin
			// output register fills at the end of a frame, empties once its beat is taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					// zero sweep over both stores
					if (clr_q == PTR_W'(MAX_DELAY - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + PTR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					ch_q    <= 1'b0;
					state_q <= S_ADDR;
				end
				S_ADDR: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= (filter_mode_q != sfe_pkg::MODE_NONE) ? S_F1 : S_W1;
				end
				S_F1: state_q <= S_F2;
				S_F2: state_q <= S_F3;
				S_F3: state_q <= S_F4;
				S_F4: begin
					fv_q[ch_q]  <= fv_new;
					rem_q[ch_q] <= rem_new;
					state_q     <= S_F5;
				end
				S_F5: state_q <= S_W1;
				S_W1: state_q <= S_W2;
				S_W2: state_q <= S_W3;
				S_W3: state_q <= S_W4;
				S_W4: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						state_q <= same_q ? S_DONE : S_Q1;
					end
				end
				S_Q1: state_q <= S_Q2;
				S_Q2: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						ptr_q   <= (ptr_nxt >= len_q) ? '0 : ptr_nxt[PTR_W-1:0];
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			in_l_q <= in_left;
			in_r_q <= in_right;
		end
		if (state_q == S_SETUP) begin
			len_q <= len_eff[LEN_W-1:0];
			off_q <= off_eff[LEN_W-1:0];
			// pointer left beyond a shortened line restarts at zero
			p_q   <= (CMP_W'(ptr_q) >= len_eff) ? '0 : ptr_q;
		end
		if (state_q == S_ADDR) begin
			q_q    <= q_wrap[PTR_W-1:0];
			same_q <= (q_wrap[PTR_W-1:0] == p_q);
		end
		case (state_q)
			S_LOAD: v_q <= AW'(signed'(rd_ch));
			S_F2:   acc_q <= prod[FW-1:0];
			S_F3:   acc_q <= acc_q + prod[FW-1:0] + FW'(rem_q[ch_q]);
			S_F5: begin
				if (filter_mode_q == sfe_pkg::MODE_LOW) begin
					v_q <= AW'(fv_q[ch_q]);
				end else begin
					v_q <= v_q - AW'(fv_q[ch_q]);
				end
			end
			S_W2:   wet_q <= div256_wrap(prod);
			S_W3:   fbv_q <= div256_wrap(prod);
			S_W4:   res_q[ch_q] <= wet_q + div256_wrap(prod);
			default: begin
			end
		endcase
		if (state_q == S_DONE && out_free) begin
			out_left_q  <= res_q[0];
			out_right_q <= res_q[1];
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = signed'(out_left_q);
	assign out_right = signed'(out_right_q);

	// a taken frame holds off the next one
	`SFE_ASSERT_NEXT(a_busy_after_beat, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while busy")
	// pointer sits inside the line once setup is done
	`SFE_ASSERT_IMPLY(a_ptr_in_line, clk, arst_n, state_q == S_ADDR, LEN_W'(p_q) < len_q, "pointer beyond line")
	// right write position inside the line
	`SFE_ASSERT_IMPLY(a_q_in_line, clk, arst_n, state_q == S_LOAD, LEN_W'(q_q) < len_q, "right position beyond line")
	// a result appears only at the end of a frame
	`SFE_ASSERT_IMPLY(a_out_from_done, clk, arst_n, $rose(out_valid), $past(state_q) == S_DONE, "result outside done")

endmodule

### hdl/sfe_ram.sv
// ----------------------------------------------------------------------------
// sfe_ram
// single-port delay store with registered read data
// ----------------------------------------------------------------------------
module sfe_ram #(
	parameter int DEPTH = sfe_pkg::MAX_DELAY_DEF
) (
	input  logic                          clk,
	input  sfe_pkg::ram_ctl_t             ctl,
	input  logic [$clog2(DEPTH)-1:0]      addr,
	input  logic [sfe_pkg::SAMPLE_W-1:0]  wdata,
	output logic [sfe_pkg::SAMPLE_W-1:0]  rdata
);

	logic [sfe_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
	logic [sfe_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem_q[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/sfe_mul.sv
// ----------------------------------------------------------------------------
// sfe_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module sfe_mul (
	input  logic                               clk,
	input  logic signed [sfe_pkg::MUL_A_W-1:0] a,
	input  logic signed [sfe_pkg::MUL_B_W-1:0] b,
	output logic signed [sfe_pkg::PROD_W-1:0]  prod
);

	logic signed [sfe_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= sfe_pkg::PROD_W'(a) * sfe_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

### tb/sv/tb_stereo_feedback_echo.sv
// ----------------------------------------------------------------------------
// tb_stereo_feedback_echo
// self-checking bench for the stereo feedback echo
// ----------------------------------------------------------------------------
// stereo frames enter over the valid/stall input channel. A software copy of
// the echo keeps both delay stores, the shared line pointer, the loop filter
// state and the registers. It works out each stereo result on the beat that
// takes the frame in. Results are checked in order as they leave the block.
// Directed tests cover sample and gain extremes, every filter mode, and the
// corner cases of the length, offset and pointer. Randomized phases follow.
// Each phase uses new register settings and its own mix of sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_stereo_feedback_echo;
	timeunit 1ns;
	timeprecision 1ps;

	import sfe_pkg::*;

	// depth of each delay store, the block runs with its default size
	localparam int ECHO_DEPTH = MAX_DELAY_DEF;

	// high-pass has no package name, mode three falls back to high-pass
	localparam logic [MODE_W-1:0] MODE_HIGH     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HIGH_ALT = 2'd3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	localparam int unsigned UNITY_GAIN = 256;
	localparam int unsigned COEF_ONE   = 32768;
	localparam int unsigned GAIN_TOP   = (1 << GAIN_W) - 1;
	localparam int unsigned LEN_TOP    = (1 << LEN_CFG_W) - 1;
	localparam int unsigned COEF_TOP   = (1 << COEF_W) - 1;

	// quiet time before a register write and at the end, above the worst latency
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 15;
	localparam int PHASE_FRAMES  = 70;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	typedef struct {
		logic [GAIN_W-1:0]    dry;
		logic [GAIN_W-1:0]    wet;
		logic [GAIN_W-1:0]    fb;
		logic [LEN_CFG_W-1:0] len;
		logic [LEN_CFG_W-1:0] offset;
		logic [MODE_W-1:0]    mode;
		logic [COEF_W-1:0]    a0;
		logic [COEF_W-1:0]    b1;
	} echo_regs_t;

	// every input is driven to a known value from time zero
	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] in_left   = '0;
	logic signed [SAMPLE_W-1:0] in_right  = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] out_left;
	logic signed [SAMPLE_W-1:0] out_right;

	// predictor state: registers, delay stores, pointer and loop filter
	echo_regs_t                 regs;
	bit signed [SAMPLE_W-1:0]   echo_line [2][ECHO_DEPTH];
	int                         line_ptr;
	int                         pole_value [2];
	shortint                    pole_rem [2];

	// stereo results still owed by the block, oldest first
	frame_t                     echo_due [$];

	int gap_pct;
	int stall_pct;
	int frames_sent;
	int results_checked;
	int reg_writes;
	int faults;

	stereo_feedback_echo dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_left   (in_left),
		.in_right  (in_right),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_left  (out_left),
		.out_right (out_right)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// hard stop, several times the slowest clean run including the store sweep
	initial begin
		#3_000_000;
		$display("stereo_feedback_echo verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// one channel: read the delayed sample, filter it if asked, then mix the
	// output, write the feedback back and add the input at its write position
	function automatic logic signed [SAMPLE_W-1:0] echo_channel(input int ch,
			input longint din, input int p, input int len, input int off);
		longint                     v;
		longint                     acc_full;
		longint                     s;
		longint                     mix;
		logic [31:0]                acc;
		logic signed [SAMPLE_W-1:0] wet;
		int                         q;
		v = echo_line[ch][p];
		// filter state is left alone with the filter off
		if (regs.mode != MODE_NONE) begin
			// accumulator wraps at 32 bits, remainder carries the lost fraction
			acc_full = v * longint'(regs.a0) + longint'(pole_value[ch]) * longint'(regs.b1)
				+ longint'(pole_rem[ch]);
			acc = acc_full[31:0];
			s = longint'($signed(acc));
			pole_rem[ch] = shortint'(s % 32768);
			pole_value[ch] = int'(s / 32768);
			v = (regs.mode == MODE_LOW) ? longint'(pole_value[ch])
				: v - longint'(pole_value[ch]);
		end
		wet = SAMPLE_W'(v * longint'(regs.wet) / 256);
		echo_line[ch][p] = SAMPLE_W'(v * longint'(regs.fb) / 256);
		// right channel writes ahead by the offset, wrapped at the length
		q = p;
		if (ch == 1 && off != 0) begin
			q = p + off;
			if (q >= len)
				q -= len;
		end
		echo_line[ch][q] = SAMPLE_W'(longint'(echo_line[ch][q]) + din);
		mix = longint'(wet) + din * longint'(regs.dry) / 256;
		return SAMPLE_W'(mix);
	endfunction

	// one stereo frame: clamp length and offset, fix the pointer, run both sides
	function automatic frame_t echo_frame(input logic signed [SAMPLE_W-1:0] left,
			input logic signed [SAMPLE_W-1:0] right);
		frame_t res;
		int     len;
		int     off;
		len = int'(regs.len);
		if (len == 0)
			len = 1;
		if (len > ECHO_DEPTH)
			len = ECHO_DEPTH;
		off = int'(regs.offset);
		if (off > len)
			off = len;
		// a pointer left past a shortened line restarts at zero
		if (line_ptr >= len)
			line_ptr = 0;
		res.left = echo_channel(0, longint'(left), line_ptr, len, off);
		res.right = echo_channel(1, longint'(right), line_ptr, len, off);
		line_ptr++;
		if (line_ptr >= len)
			line_ptr = 0;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// channel drivers and result checker
	// ------------------------------------------------------------------------

	// receiver stalls at random, the rate is set per phase
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_miss(input string what, input longint want, input longint got);
		faults++;
		$display("%0t ns %s: expected %0d actual %0d", $time, what, want, got);
	endtask

	// every output beat is compared with the oldest owed result
	always @(posedge clk) begin
		frame_t due;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (echo_due.size() == 0) begin
				faults++;
				$display("%0t ns unexpected output beat: expected none actual %0d %0d",
					$time, out_left, out_right);
			end else begin
				due = echo_due.pop_front();
				if (out_left !== due.left)
					report_miss("out_left", due.left, out_left);
				if (out_right !== due.right)
					report_miss("out_right", due.right, out_right);
			end
		end
	end

	// offer one frame, optionally after random gaps, and hold it until taken
	task automatic push_frame(input logic signed [SAMPLE_W-1:0] left,
			input logic signed [SAMPLE_W-1:0] right);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_left <= left;
		in_right <= right;
		do @(posedge clk); while (in_stall);
		// beat taken at this edge, predict its result now
		echo_due.push_back(echo_frame(left, right));
		frames_sent++;
	endtask

	// drop valid, wait for every owed result and let the pipeline run dry
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (echo_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write; bits above the register width carry random junk
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		logic [CFG_W-1:0] keep;
		logic [CFG_W-1:0] data;
		case (idx)
			REG_DRY, REG_WET, REG_FB: keep = CFG_W'({GAIN_W{1'b1}});
			REG_MODE: keep = CFG_W'({MODE_W{1'b1}});
			REG_A0, REG_B1: keep = CFG_W'({COEF_W{1'b1}});
			default: keep = '1;
		endcase
		data = (CFG_W'(value) & keep) | (CFG_W'($urandom) & ~keep);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_DRY:    regs.dry = data[GAIN_W-1:0];
			REG_WET:    regs.wet = data[GAIN_W-1:0];
			REG_FB:     regs.fb = data[GAIN_W-1:0];
			REG_LEN:    regs.len = data[LEN_CFG_W-1:0];
			REG_OFFSET: regs.offset = data[LEN_CFG_W-1:0];
			REG_MODE:   regs.mode = data[MODE_W-1:0];
			REG_A0:     regs.a0 = data[COEF_W-1:0];
			REG_B1:     regs.b1 = data[COEF_W-1:0];
		endcase
		reg_writes++;
	endtask

	task automatic set_idle(input int gap, input int stall);
		gap_pct = gap;
		stall_pct = stall;
	endtask

	// mostly full-range noise, some rail values, some quiet signal
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		if (r < 70)
			return SAMPLE_W'($urandom);
		if (r < 85) begin
			k = $urandom_range(3);
			return (k == 0) ? SAMPLE_MAX : (k == 1) ? SAMPLE_MIN : (k == 2) ? '0 : '1;
		end
		return SAMPLE_W'($urandom_range(512) - 256);
	endfunction

	// unity often, nominal range mostly, the full field now and then
	function automatic int unsigned pick_gain();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 15)
			return UNITY_GAIN;
		if (r < 70)
			return $urandom_range(UNITY_GAIN);
		return $urandom_range(GAIN_TOP);
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset register values, stores swept to zero so the output is the input
	task automatic test_reset_defaults();
		set_idle(0, 0);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(16'sd0, 16'sd0);
		push_frame(-16'sd1, 16'sd1);
		push_frame(16'sh5555, 16'shAAAA);
	endtask

	// gains at the top of the field, sums and products wrap to 16 bits
	task automatic test_gain_wrap();
		settle_idle();
		write_reg(REG_LEN, 3);
		write_reg(REG_OFFSET, 1);
		write_reg(REG_DRY, GAIN_TOP);
		write_reg(REG_WET, GAIN_TOP);
		write_reg(REG_FB, GAIN_TOP);
		push_frame(SAMPLE_MAX, SAMPLE_MAX);
		push_frame(SAMPLE_MIN, SAMPLE_MIN);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(16'sd1, -16'sd1);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
	endtask

	// low-pass, high-pass with coefficients that overflow the accumulator,
	// and mode three acting as high-pass
	task automatic test_loop_filters();
		settle_idle();
		write_reg(REG_LEN, 2);
		write_reg(REG_OFFSET, 0);
		write_reg(REG_DRY, UNITY_GAIN / 2);
		write_reg(REG_WET, UNITY_GAIN);
		write_reg(REG_FB, 200);
		write_reg(REG_MODE, MODE_LOW);
		write_reg(REG_A0, COEF_ONE / 2);
		write_reg(REG_B1, COEF_ONE / 2);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(-16'sd1, 16'sd1);
		settle_idle();
		write_reg(REG_MODE, MODE_HIGH);
		write_reg(REG_A0, COEF_TOP);
		write_reg(REG_B1, COEF_TOP);
		push_frame(SAMPLE_MIN, SAMPLE_MAX);
		push_frame(SAMPLE_MAX, SAMPLE_MAX);
		settle_idle();
		write_reg(REG_MODE, MODE_HIGH_ALT);
		write_reg(REG_A0, COEF_ONE);
		write_reg(REG_B1, 0);
		push_frame(16'sd12345, -16'sd12345);
		push_frame(SAMPLE_MIN, SAMPLE_MIN);
	endtask

	// zero length, length past the store, offset past and at the length,
	// pointer past a shortened line, old contents back once it grows again
	task automatic test_length_limits();
		settle_idle();
		write_reg(REG_MODE, MODE_NONE);
		write_reg(REG_LEN, 0);
		write_reg(REG_OFFSET, 5);
		push_frame(SAMPLE_MAX, 16'sd77);
		push_frame(-16'sd300, SAMPLE_MIN);
		settle_idle();
		write_reg(REG_LEN, LEN_TOP);
		write_reg(REG_OFFSET, LEN_TOP);
		push_frame(16'sd1000, -16'sd1000);
		settle_idle();
		write_reg(REG_LEN, 7);
		write_reg(REG_OFFSET, 7);
		push_frame(16'sd4000, 16'sd5000);
		push_frame(-16'sd4000, -16'sd5000);
		push_frame(SAMPLE_MAX, SAMPLE_MIN);
		push_frame(16'sd3, -16'sd3);
		settle_idle();
		write_reg(REG_LEN, 2);
		push_frame(16'sd100, 16'sd200);
		settle_idle();
		write_reg(REG_LEN, 7);
		push_frame(16'sd0, 16'sd0);
		push_frame(16'sd0, 16'sd0);
	endtask

	// new register set per phase, mostly short lines so the echo builds up
	task automatic shuffle_regs();
		int unsigned r;
		int unsigned len;
		int unsigned off;
		int unsigned a0;
		int unsigned b1;
		r = $urandom_range(99);
		if (r < 70)
			len = $urandom_range(48, 1);
		else if (r < 85)
			len = $urandom_range(600, 49);
		else if (r < 90)
			len = 0;
		else if (r < 95)
			len = $urandom_range(LEN_TOP, ECHO_DEPTH - 4);
		else
			len = $urandom_range(LEN_TOP);
		r = $urandom_range(99);
		if (r < 45)
			off = $urandom_range(len);
		else if (r < 60)
			off = 0;
		else if (r < 75)
			off = len;
		else
			off = $urandom_range(LEN_TOP);
		// stable filter pairs mostly, then wider and raw coefficients
		r = $urandom_range(99);
		if (r < 50) begin
			a0 = $urandom_range(COEF_ONE);
			b1 = COEF_ONE - a0;
		end else if (r < 80) begin
			a0 = $urandom_range(COEF_ONE);
			b1 = $urandom_range(COEF_ONE);
		end else begin
			a0 = $urandom_range(COEF_TOP);
			b1 = $urandom_range(COEF_TOP);
		end
		write_reg(REG_DRY, pick_gain());
		write_reg(REG_WET, pick_gain());
		write_reg(REG_FB, pick_gain());
		write_reg(REG_LEN, len);
		write_reg(REG_OFFSET, off);
		write_reg(REG_MODE, $urandom_range(3));
		write_reg(REG_A0, a0);
		write_reg(REG_B1, b1);
	endtask

	// random frames, idling mix rotates: none, sender gaps, receiver stalls, both
	task automatic test_random_traffic();
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_idle();
			shuffle_regs();
			case (phase % 4)
				0: set_idle(0, 0);
				1: set_idle(57, 0);
				2: set_idle(0, 57);
				default: set_idle(27, 27);
			endcase
			for (int n = 0; n < PHASE_FRAMES; n++)
				push_frame(pick_sample(), pick_sample());
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		regs.dry = DRY_RST;
		regs.wet = WET_RST;
		regs.fb = FB_RST;
		regs.len = LEN_RST;
		regs.offset = OFFSET_RST;
		regs.mode = MODE_NONE;
		regs.a0 = '0;
		regs.b1 = '0;
		set_idle(0, 0);

		// reset held low from time zero, released on a falling edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the block sweeps both stores after reset with in_stall high
		repeat (2) @(posedge clk);
		while (in_stall)
			@(posedge clk);

		test_reset_defaults();
		test_gain_wrap();
		test_loop_filters();
		test_length_limits();
		test_random_traffic();

		// all frames taken, wait for the last results and any stray beats
		settle_idle();

		$display("%0d stereo frames sent, %0d output beats checked, %0d mismatches",
			frames_sent, results_checked, faults);
		$display("%0d register writes over directed cases and %0d random settings",
			reg_writes, RANDOM_PHASES);
		if (faults == 0) begin
			$display("stereo_feedback_echo verification clean");
		end else begin
			$display("stereo_feedback_echo verification failed");
		end
		$finish;
	end

endmodule
